/* hdl/thermistor_code_to_temperature_top_assert.svh */
// Assertion macros shared by the thermistor temperature RTL
`ifndef THERMISTOR_CODE_TO_TEMPERATURE_TOP_ASSERT_SVH
`define THERMISTOR_CODE_TO_TEMPERATURE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tcc assertion failed");
`define TCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tcc assertion failed");
`else
`define TCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/tcc_pkg.sv */
// Types and constants for the thermistor temperature pipeline
package tcc_pkg;
	localparam int LOG_STEPS = 24;
	localparam int DIV_STEPS = 49;
	localparam int QUO_W     = 49;
	localparam int DIV_YW    = 40;
	localparam int DIV_RW    = 41;

	localparam logic signed [32:0] LOG2_1000_Q24 = 33'sd167198116;
	localparam logic signed [31:0] LN2_Q30       = 32'sd744261118;
	localparam logic signed [39:0] COEF_A_Q40    = 40'sd1044317488;
	localparam logic signed [31:0] COEF_B_Q40    = 32'sd238017053;
	localparam logic signed [31:0] COEF_C_Q40    = 32'sd531390;
	localparam logic signed [31:0] COEF_D_Q40    = 32'sd121655;
	localparam logic signed [50:0] TEMP_LIMIT    = 51'sd70000;
	localparam logic signed [50:0] KELVIN_Q8     = 51'sd69926;

	typedef struct packed {
		logic [30:0] x;
		logic [23:0] frac;
		logic [5:0]  p;
		logic        nonpos;
	} lg_t;

	typedef struct packed {
		logic [DIV_RW-1:0] r;
		logic [QUO_W-1:0]  q;
		logic [DIV_YW-1:0] y;
		logic              nonpos;
		logic              yzero;
		logic              yneg;
	} dv_t;
endpackage

/* hdl/tcc_log_cell.sv */
// One fractional bit of log2 by squaring the Q30 mantissa
module tcc_log_cell (
	input  logic         clk,
	input  logic         en,
	input  tcc_pkg::lg_t d,
	output tcc_pkg::lg_t q
);
	import tcc_pkg::*;

	logic [61:0] sq;
	logic [31:0] sh;
	lg_t         nx;

	always_comb begin
		sq = 62'(d.x) * 62'(d.x);
		sh = sq[61:30];
		nx = d;
		if (sh[31]) begin
			nx.x    = sh[31:1];
			nx.frac = {d.frac[22:0], 1'b1};
		end else begin
			nx.x    = sh[30:0];
			nx.frac = {d.frac[22:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end
endmodule

/* hdl/tcc_div_cell.sv */
// One restoring-division step: shift in a dividend bit, trial subtract
module tcc_div_cell (
	input  logic         clk,
	input  logic         en,
	input  logic         lead,
	input  tcc_pkg::dv_t d,
	output tcc_pkg::dv_t q
);
	import tcc_pkg::*;

	logic [DIV_RW-1:0] rs;
	dv_t               nx;

	always_comb begin
		rs = {d.r[DIV_RW-2:0], lead};
		nx = d;
		if (rs >= DIV_RW'(d.y)) begin
			nx.r = rs - DIV_RW'(d.y);
			nx.q = {d.q[QUO_W-2:0], 1'b1};
		end else begin
			nx.r = rs;
			nx.q = {d.q[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end
endmodule

/* hdl/thermistor_code_to_temperature_top.sv */
// Top level: thermistor ADC code to Q8 Celsius via Steinhart-Hart
//
//  channel | signals                              | dir
//  adc     | adc_valid, adc_stall, adc_code       | in
//  temp    | temp_valid, temp_stall,              | out
//          | temperature_q8, range_error          |
//
// One code per cycle unless a stalled result holds the pipeline; 24 log cells, 49 divider cells.
// Throughput is set by the shared pipeline enable: one transfer per cycle while not stalled.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled result freezes the whole pipeline and raises adc_stall.
`include "thermistor_code_to_temperature_top_assert.svh"
module thermistor_code_to_temperature_top #(
	parameter int ADC_BITS = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adc_valid,
	output logic                       adc_stall,
	input  logic signed [ADC_BITS-1:0] adc_code,
	output logic                       temp_valid,
	input  logic                       temp_stall,
	output logic signed [17:0]         temperature_q8,
	output logic                       range_error
);
	import tcc_pkg::*;

	localparam int NW   = ADC_BITS + 8;
	localparam int NSW  = (NW > 31) ? NW : 31;
	// n, leading one, mantissa, log cells, l2/ln/3 Horner/div setup, div cells, output
	localparam int NSTG = 3 + LOG_STEPS + 6 + DIV_STEPS + 1;

	logic            en;
	logic [NSTG-1:0] vld_q;

	assign en         = !(vld_q[NSTG-1] && temp_stall);
	assign adc_stall  = !en;
	assign temp_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NSTG-2:0], adc_valid};
		end
	end

	// stage 1: n = 66*code - 25*2^(ADC_BITS-1)
	logic signed [NW-1:0] cx, n_d, n_s1;
	logic                 np_s1;
	always_comb begin
		cx  = NW'(adc_code);
		n_d = cx * NW'(66) - (NW'(25) << (ADC_BITS - 1));
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s1  <= n_d;
			np_s1 <= (n_d <= 0);
		end
	end

	// stage 2: leading one
	logic [5:0]    p_d, p_s2;
	logic [NW-1:0] n_s2;
	logic          np_s2;
	always_comb begin
		p_d = '0;
		for (int i = 0; i < NW; i++) begin
			if (n_s1[i]) begin
				p_d = 6'(i);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			n_s2  <= n_s1;
			p_s2  <= p_d;
			np_s2 <= np_s1;
		end
	end

	// stage 3: mantissa to Q30 in [1,2)
	logic [NSW-1:0] nx;
	lg_t            lg_s [0:LOG_STEPS];
	always_comb begin
		nx = NSW'(n_s2) << (6'(NSW - 1) - p_s2);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lg_s[0].x      <= nx[NSW-1 -: 31];
			lg_s[0].frac   <= '0;
			lg_s[0].p      <= p_s2;
			lg_s[0].nonpos <= np_s2;
		end
	end

	for (genvar g = 0; g < LOG_STEPS; g++) begin : g_log
		tcc_log_cell u_cell (
			.clk(clk),
			.en (en),
			.d  (lg_s[g]),
			.q  (lg_s[g+1])
		);
	end

	// log2(R) in Q24, then ln(R)
	logic signed [32:0] l2_s;
	logic               np_l2;
	always_ff @(posedge clk) begin
		if (en) begin
			l2_s  <= $signed({3'b000, lg_s[LOG_STEPS].p, lg_s[LOG_STEPS].frac})
			         + LOG2_1000_Q24 - (33'(ADC_BITS - 1) << 24);
			np_l2 <= lg_s[LOG_STEPS].nonpos;
		end
	end

	logic signed [63:0] ln_p;
	logic signed [31:0] lnr_s, lnr_h1, lnr_h2;
	logic               np_ln, np_h1, np_h2, np_h3;
	assign ln_p = 64'(l2_s) * 64'(LN2_Q30);
	always_ff @(posedge clk) begin
		if (en) begin
			lnr_s <= ln_p[61:30];
			np_ln <= np_l2;
		end
	end

	// Horner's rule, one product per stage
	logic signed [63:0] h1_p, h2_p, h3_p;
	logic signed [31:0] t1_s, t2_s;
	logic signed [39:0] y_s;
	assign h1_p = 64'(lnr_s) * 64'(COEF_D_Q40);
	assign h2_p = 64'(lnr_h1) * 64'(t1_s);
	assign h3_p = 64'(lnr_h2) * 64'(t2_s);
	always_ff @(posedge clk) begin
		if (en) begin
			t1_s   <= COEF_C_Q40 + h1_p[55:24];
			lnr_h1 <= lnr_s;
			np_h1  <= np_ln;
			t2_s   <= COEF_B_Q40 + h2_p[55:24];
			lnr_h2 <= lnr_h1;
			np_h2  <= np_h1;
			y_s    <= COEF_A_Q40 + h3_p[63:24];
			np_h3  <= np_h2;
		end
	end

	// divider setup: 2^48 / y
	dv_t dv_s [0:DIV_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].r      <= '0;
			dv_s[0].q      <= '0;
			dv_s[0].y      <= (y_s > 0) ? DIV_YW'(y_s) : DIV_YW'(1);
			dv_s[0].nonpos <= np_h3;
			dv_s[0].yzero  <= (y_s == 0);
			dv_s[0].yneg   <= (y_s < 0);
		end
	end

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		tcc_div_cell u_cell (
			.clk (clk),
			.en  (en),
			.lead(g == 0),
			.d   (dv_s[g]),
			.q   (dv_s[g+1])
		);
	end

	// round: floor(2^48/y - 69925.9) = Q - 69926 + (10r >= 9y)
	dv_t                dz;
	logic [43:0]        r10, y9;
	logic signed [50:0] tv;
	logic signed [17:0] t_d;
	logic               e_d;
	always_comb begin
		dz  = dv_s[DIV_STEPS];
		r10 = 44'(dz.r) * 44'd10;
		y9  = 44'(dz.y) * 44'd9;
		tv  = $signed({2'b00, dz.q}) - KELVIN_Q8 + 51'(r10 >= y9);
		t_d = tv[17:0];
		e_d = 1'b0;
		if (dz.nonpos) begin
			t_d = '0;
			e_d = 1'b1;
		end else if (dz.yzero) begin
			t_d = TEMP_LIMIT[17:0];
			e_d = 1'b1;
		end else if (dz.yneg) begin
			t_d = -TEMP_LIMIT[17:0];
			e_d = 1'b1;
		end else if (tv > TEMP_LIMIT) begin
			t_d = TEMP_LIMIT[17:0];
			e_d = 1'b1;
		end else if (tv < -TEMP_LIMIT) begin
			t_d = -TEMP_LIMIT[17:0];
			e_d = 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			temperature_q8 <= t_d;
			range_error    <= e_d;
		end
	end

	`TCC_ASSERT_IMP(a_stall_src, clk, arst_n, adc_stall, temp_valid && temp_stall)
	`TCC_ASSERT_NXT(a_vld_enter, clk, arst_n, adc_valid && !adc_stall, vld_q[0])
	`TCC_ASSERT_IMP(a_range, clk, arst_n, temp_valid && !range_error, temperature_q8 <= 18'sd70000 && temperature_q8 >= -18'sd70000)
endmodule
